FILE: rtl/arp_pkg.sv
// Shared widths, codes and types for the ARP address cache.
package arp_pkg;

  localparam int DEFAULT_ENTRIES = 16;

  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int SLOT_W      = 4;
  localparam int OUTCOME_W   = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  // Command codes carried in the input tuser.
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Store outcome codes.
  localparam logic [OUTCOME_W-1:0] OUTCOME_UPDATED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILLED  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICTED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd2;

  typedef struct packed {
    logic [IP_W-1:0] own_ip;
    logic [IP_W-1:0] net_mask;
    logic [IP_W-1:0] gateway_ip;
  } arp_cfg_t;

  // Input beat payload, ip_addr in the low bits.
  typedef struct packed {
    logic [MAC_W-1:0] mac_addr;
    logic [IP_W-1:0]  ip_addr;
  } arp_item_t;

  // Result payload, hit in the lowest bit.
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [OUTCOME_W-1:0] store_outcome;
    logic [IP_W-1:0]      next_hop_ip;
    logic [MAC_W-1:0]     mac_out;
    logic                 hit;
  } arp_res_t;

endpackage

FILE: rtl/arp_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module arp_ram import arp_pkg::*; #(
  parameter int WIDTH = IP_W,
  parameter int DEPTH = DEFAULT_ENTRIES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/arp_ctrl.sv
// Scan sequencer, valid bits and result register of the ARP address cache.
module arp_ctrl import arp_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  arp_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  arp_item_t        in_item,
  output logic             ip_we,
  output logic [IDX_W-1:0] ip_waddr,
  output logic [IP_W-1:0]  ip_wdata,
  output logic             ip_re,
  output logic [IDX_W-1:0] ip_raddr,
  input  logic [IP_W-1:0]  ip_rdata,
  output logic             mac_we,
  output logic [IDX_W-1:0] mac_waddr,
  output logic [MAC_W-1:0] mac_wdata,
  output logic             mac_re,
  output logic [IDX_W-1:0] mac_raddr,
  input  logic [MAC_W-1:0] mac_rdata,
  output logic             out_valid,
  input  logic             out_ready,
  output arp_res_t         out_res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RES  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r;
  logic               cmd_r;
  logic [IP_W-1:0]    addr_r;
  logic [MAC_W-1:0]   mac_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               issue_done_r;
  logic               pipe_vld_r;
  logic [IDX_W-1:0]   pipe_idx_r;
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [ENTRIES-1:0] valid_r;
  arp_res_t           res_r;
  arp_res_t           out_r;
  logic               out_valid_r;

  logic               accept;
  logic               use_gw;
  logic [IP_W-1:0]    route_addr;
  logic               hit_now;
  logic               free_now;
  logic               scan_end;
  logic [IDX_W-1:0]   wr_idx;
  logic               out_load;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Off-subnet lookups go to the gateway when routing is configured.
  assign use_gw = (in_cmd == CMD_LOOKUP) && (cfg.net_mask != '0) &&
                  ((in_item.ip_addr & cfg.net_mask) != (cfg.own_ip & cfg.net_mask)) &&
                  (cfg.gateway_ip != '0);
  assign route_addr = use_gw ? cfg.gateway_ip : in_item.ip_addr;

  // The compare stage sits in the cycle after the read issue.
  assign hit_now  = pipe_vld_r && valid_r[pipe_idx_r] && (ip_rdata == addr_r);
  assign free_now = pipe_vld_r && !valid_r[pipe_idx_r];
  assign scan_end = pipe_vld_r && (pipe_idx_r == LAST_IDX);

  assign wr_idx = match_found_r ? match_idx_r :
                  free_found_r  ? free_idx_r  : '0;

  // The result register takes a new beat when it is empty or being drained.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign ip_re     = (state_r == S_SCAN) && !issue_done_r;
  assign ip_raddr  = scan_idx_r;
  assign ip_we     = (state_r == S_RES) && (cmd_r == CMD_STORE);
  assign ip_waddr  = wr_idx;
  assign ip_wdata  = addr_r;
  assign mac_we    = ip_we;
  assign mac_waddr = wr_idx;
  assign mac_wdata = mac_r;
  assign mac_re    = (state_r == S_RES) && (cmd_r == CMD_LOOKUP) && match_found_r;
  assign mac_raddr = match_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pipe_vld_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r         <= in_cmd;
            addr_r        <= route_addr;
            mac_r         <= in_item.mac_addr;
            scan_idx_r    <= '0;
            issue_done_r  <= 1'b0;
            pipe_vld_r    <= 1'b0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          pipe_vld_r <= ip_re;
          pipe_idx_r <= scan_idx_r;
          if (ip_re) begin
            if (scan_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              scan_idx_r <= scan_idx_r + 1'b1;
            end
          end
          if (hit_now && !match_found_r) begin
            match_found_r <= 1'b1;
            match_idx_r   <= pipe_idx_r;
          end
          if (free_now && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= pipe_idx_r;
          end
          if (scan_end) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          res_r.mac_out     <= '0;
          res_r.next_hop_ip <= addr_r;
          if (cmd_r == CMD_STORE) begin
            valid_r[wr_idx] <= 1'b1;
            res_r.hit       <= 1'b0;
            res_r.slot      <= SLOT_W'(wr_idx);
            if (match_found_r) begin
              res_r.store_outcome <= OUTCOME_UPDATED;
            end else if (free_found_r) begin
              res_r.store_outcome <= OUTCOME_FILLED;
            end else begin
              res_r.store_outcome <= OUTCOME_EVICTED;
            end
            state_r <= S_OUT;
          end else if (match_found_r) begin
            res_r.hit           <= 1'b1;
            res_r.store_outcome <= OUTCOME_UPDATED;
            res_r.slot          <= SLOT_W'(match_idx_r);
            state_r             <= S_MAC;
          end else begin
            res_r.hit           <= 1'b0;
            res_r.store_outcome <= OUTCOME_UPDATED;
            res_r.slot          <= '0;
            state_r             <= S_OUT;
          end
        end
        S_MAC: begin
          res_r.mac_out <= mac_rdata;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

FILE: rtl/arp_address_cache_top.sv
// An item is compared against every entry in turn, resolved, and on a lookup hit its MAC is read;
// the block takes no new item until the result is in the output register. The scan of the
// address RAM is sequential: the RAM has a single read port and reads one entry a cycle.
// A finished result waits in the output register while the next item is scanned.
// Reset (rst_n low, synchronous) clears all valid bits, the configuration and control.
// Entry RAM contents are not cleared; unwritten entries are never read as valid.
module arp_address_cache_top import arp_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic                   in_tuser,   // cmd[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hit[0], mac_out[48:1], next_hop_ip[80:49],
                                             // store_outcome[82:81], slot[86:83], zero[87]
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  arp_cfg_t         cfg_r;
  arp_res_t         res;

  logic             ip_we;
  logic [IDX_W-1:0] ip_waddr;
  logic [IP_W-1:0]  ip_wdata;
  logic             ip_re;
  logic [IDX_W-1:0] ip_raddr;
  logic [IP_W-1:0]  ip_rdata;
  logic             mac_we;
  logic [IDX_W-1:0] mac_waddr;
  logic [MAC_W-1:0] mac_wdata;
  logic             mac_re;
  logic [IDX_W-1:0] mac_raddr;
  logic [MAC_W-1:0] mac_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:     cfg_r.own_ip     <= cfg_wdata;
        CFG_NET_MASK:   cfg_r.net_mask   <= cfg_wdata;
        CFG_GATEWAY_IP: cfg_r.gateway_ip <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  arp_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_item   (arp_item_t'(in_tdata)),
    .ip_we     (ip_we),
    .ip_waddr  (ip_waddr),
    .ip_wdata  (ip_wdata),
    .ip_re     (ip_re),
    .ip_raddr  (ip_raddr),
    .ip_rdata  (ip_rdata),
    .mac_we    (mac_we),
    .mac_waddr (mac_waddr),
    .mac_wdata (mac_wdata),
    .mac_re    (mac_re),
    .mac_raddr (mac_raddr),
    .mac_rdata (mac_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  arp_ram #(
    .WIDTH (IP_W),
    .DEPTH (ENTRIES)
  ) u_ip_ram (
    .clk   (clk),
    .we    (ip_we),
    .waddr (ip_waddr),
    .wdata (ip_wdata),
    .re    (ip_re),
    .raddr (ip_raddr),
    .rdata (ip_rdata)
  );

  arp_ram #(
    .WIDTH (MAC_W),
    .DEPTH (ENTRIES)
  ) u_mac_ram (
    .clk   (clk),
    .we    (mac_we),
    .waddr (mac_waddr),
    .wdata (mac_wdata),
    .re    (mac_re),
    .raddr (mac_raddr),
    .rdata (mac_rdata)
  );

  assign out_tdata = {1'b0, res};

`ifndef SYNTHESIS
  // Once an item is taken, the scan must run before another one is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A lookup hit never carries a store outcome.
  a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[82:81] == OUTCOME_UPDATED))
    else $error("hit result with nonzero store outcome");

  // Results without a hit carry a zero hardware address.
  a_miss_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[48:1] == '0))
    else $error("miss or store result with nonzero MAC");

  // Both table RAMs are written together, never in a cycle that reads them.
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    ip_we |-> (mac_we && !ip_re && !mac_re))
    else $error("table write overlaps a table read");
`endif

endmodule

FILE: tb/arp_address_cache_top_tb.sv
// Self-checking testbench for the ARP address cache: store and lookup beats against a predictor.
module arp_address_cache_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_ENTRIES;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 14;
  localparam int LONG_STALL = 400;
  localparam int STALL_AT = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic      cmd;
    arp_item_t body;
  } arp_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predicted table and registers.
  logic                 bind_valid [TABLE_DEPTH];
  logic [IP_W-1:0]      bind_ip    [TABLE_DEPTH];
  logic [MAC_W-1:0]     bind_mac   [TABLE_DEPTH];
  logic [IP_W-1:0]      own_ip_r = '0;
  logic [IP_W-1:0]      net_mask_r = '0;
  logic [IP_W-1:0]      gateway_ip_r = '0;

  arp_req_t pending_q[$];
  arp_res_t resolved_q[$];

  int  in_sent = 0;
  int  in_taken = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  bit  quiet = 1'b0;
  int  send_idle_pct = 10;
  int  recv_idle_pct = 10;

  arp_address_cache_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Lowest valid entry bound to addr, or -1.
  function automatic int find_binding(logic [IP_W-1:0] addr);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bind_valid[i] && bind_ip[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one item to the predicted table and returns the result it should give.
  function automatic arp_res_t resolve_item(logic cmd, arp_item_t d);
    arp_res_t r;
    int idx;
    logic [IP_W-1:0] hop;
    r = '0;
    hop = d.ip_addr;
    if (cmd == CMD_STORE) begin
      idx = find_binding(d.ip_addr);
      if (idx >= 0) begin
        bind_mac[idx] = d.mac_addr;
        r.store_outcome = OUTCOME_UPDATED;
      end else begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!bind_valid[i]) idx = i;
        end
        if (idx >= 0) begin
          r.store_outcome = OUTCOME_FILLED;
        end else begin
          idx = 0;
          r.store_outcome = OUTCOME_EVICTED;
        end
        bind_valid[idx] = 1'b1;
        bind_ip[idx] = d.ip_addr;
        bind_mac[idx] = d.mac_addr;
      end
      r.slot = SLOT_W'(idx);
    end else begin
      if (net_mask_r != '0 && (d.ip_addr & net_mask_r) != (own_ip_r & net_mask_r)
          && gateway_ip_r != '0) begin
        hop = gateway_ip_r;
      end
      idx = find_binding(hop);
      if (idx >= 0) begin
        r.hit = 1'b1;
        r.mac_out = bind_mac[idx];
        r.slot = SLOT_W'(idx);
      end
    end
    r.next_hop_ip = hop;
    return r;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // Input beats are predicted as they are accepted; result beats are checked in order.
  always @(posedge clk) begin : watch_beats
    arp_res_t got;
    arp_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        resolved_q.push_back(resolve_item(in_tuser, arp_item_t'(in_tdata)));
        in_taken <= in_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        got = arp_res_t'(out_tdata[OUT_TDATA_W-2:0]);
        if (resolved_q.size() == 0) begin
          flag_mismatch("result beat with nothing pending", '0, out_tdata[63:0]);
        end else begin
          want = resolved_q.pop_front();
          if (got.hit !== want.hit) flag_mismatch("hit", want.hit, got.hit);
          if (got.mac_out !== want.mac_out) flag_mismatch("mac_out", want.mac_out, got.mac_out);
          if (got.next_hop_ip !== want.next_hop_ip) begin
            flag_mismatch("next_hop_ip", want.next_hop_ip, got.next_hop_ip);
          end
          if (got.store_outcome !== want.store_outcome) begin
            flag_mismatch("store_outcome", want.store_outcome, got.store_outcome);
          end
          if (got.slot !== want.slot) flag_mismatch("slot", want.slot, got.slot);
        end
      end
    end
  end

  always @(negedge clk) begin : drive_items
    arp_req_t r;
    if (rst_n && (!in_tvalid || in_taken == in_sent)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        r = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= r.body;
        in_tuser <= r.cmd;
        in_sent <= in_sent + 1;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(1, 19);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // One long hold-off fills the block so that it has to stall its input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!stall_done && in_taken >= STALL_AT) begin
        stall_done <= 1'b1;
        stall_left <= LONG_STALL;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
          recv_gap <= $urandom_range(1, 19);
        end
      end
    end
  end

  task automatic queue_item(logic cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    arp_req_t r;
    r.cmd = cmd;
    r.body.ip_addr = ip;
    r.body.mac_addr = mac;
    pending_q.push_back(r);
  endtask

  // Waits until every item is in and every result is out, then lets the block settle.
  task automatic drain();
    while (pending_q.size() != 0 || in_taken != in_sent || resolved_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OWN_IP:     own_ip_r = val;
      CFG_NET_MASK:   net_mask_r = val;
      CFG_GATEWAY_IP: gateway_ip_r = val;
      default: ;
    endcase
  endtask

  // Mostly addresses from a small set, so that stores update, fill and evict and lookups hit.
  task automatic random_phase(int count);
    logic [IP_W-1:0] pool [24];
    logic [IP_W-1:0] host;
    logic [IP_W-1:0] ip;
    int pool_size;
    int sel;
    pool_size = $urandom_range(8, 24);
    for (int i = 0; i < 24; i++) begin
      host = $urandom();
      pool[i] = (i % 2 == 1) ? ((own_ip_r & net_mask_r) | (host & ~net_mask_r)) : host;
    end
    pool[0] = gateway_ip_r;
    pool[2] = '0;
    pool[4] = '1;
    pool[6] = own_ip_r;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      host = $urandom();
      if (sel < 7) ip = pool[$urandom_range(0, pool_size - 1)];
      else if (sel < 8) ip = (own_ip_r & net_mask_r) | (host & ~net_mask_r);
      else ip = host;
      queue_item(($urandom_range(0, 1) == 0) ? CMD_STORE : CMD_LOOKUP, ip,
                 {16'($urandom()), 32'($urandom())});
    end
  endtask

  function automatic logic [IP_W-1:0] pick_reg_value(logic [IP_W-1:0] pool_addr);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return '1 << $urandom_range(1, 31);
      3: return pool_addr;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [IP_W-1:0] own_v;
    logic [IP_W-1:0] mask_v;
    logic [IP_W-1:0] gw_v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      bind_valid[i] = 1'b0;
      bind_ip[i] = '0;
      bind_mac[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table, extremes of the fields, update, fill to full and evict entry 0.
    queue_item(CMD_LOOKUP, '0, '1);
    queue_item(CMD_STORE, '0, '0);
    queue_item(CMD_STORE, '1, '1);
    queue_item(CMD_LOOKUP, '1, '0);
    queue_item(CMD_STORE, '1, 48'h0123_4567_89AB);
    queue_item(CMD_LOOKUP, '0, 48'h5555_5555_5555);
    for (int i = 2; i < TABLE_DEPTH; i++) begin
      queue_item(CMD_STORE, 32'hC0A8_0000 + i, {16'($urandom()), 32'($urandom())});
    end
    queue_item(CMD_STORE, 32'h0A0B_0C0D, 48'hAAAA_5555_AAAA);
    queue_item(CMD_LOOKUP, '0, '0);
    drain();

    // Gateway routing on and off.
    write_reg(CFG_OWN_IP, 32'h0A00_0001);
    write_reg(CFG_NET_MASK, 32'hFFFF_FF00);
    write_reg(CFG_GATEWAY_IP, 32'h0A00_00FE);
    queue_item(CMD_STORE, 32'h0A00_00FE, 48'hFEDC_BA98_7654);
    queue_item(CMD_LOOKUP, 32'h0808_0808, '0);
    queue_item(CMD_LOOKUP, 32'h0A00_0005, '0);
    drain();
    write_reg(CFG_GATEWAY_IP, '0);
    queue_item(CMD_LOOKUP, 32'h0808_0808, '0);
    drain();
    write_reg(CFG_NET_MASK, '0);
    write_reg(CFG_GATEWAY_IP, '1);
    queue_item(CMD_LOOKUP, 32'h0808_0808, '0);
    drain();
    // An out-of-range index must leave the registers alone.
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_NET_MASK, 32'hFF00_0000);
    queue_item(CMD_LOOKUP, 32'h0808_0808, '0);
    queue_item(CMD_STORE, '1, '0);
    queue_item(CMD_LOOKUP, 32'h0808_0808, '0);
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin
          own_v = '1;
          mask_v = '1;
          gw_v = '1;
        end
        1: begin
          own_v = '0;
          mask_v = '0;
          gw_v = $urandom();
        end
        2: begin
          own_v = $urandom();
          mask_v = 32'hFFFF_FF00;
          gw_v = (own_v & mask_v) | 32'h0000_0001;
        end
        default: begin
          own_v = pick_reg_value($urandom());
          mask_v = pick_reg_value('1 << $urandom_range(1, 31));
          gw_v = pick_reg_value((own_v & mask_v) | ($urandom() & ~mask_v));
        end
      endcase
      write_reg(CFG_OWN_IP, own_v);
      write_reg(CFG_NET_MASK, mask_v);
      write_reg(CFG_GATEWAY_IP, gw_v);
      if (k % 2 == 1) write_reg(CFG_UNUSED, $urandom());
      send_idle_pct = (k % 3 == 0) ? 0 : $urandom_range(5, 40);
      recv_idle_pct = (k % 4 == 1) ? 0 : $urandom_range(5, 40);
      random_phase(230);
      drain();
    end

    quiet = 1'b1;
    random_phase(150);
    drain();

    if (mismatches == 0 && resolved_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
